[sv/ddsrf_decoupling_filter_unit_assert.svh]
// Assertion macros for the decoupling filter unit.
`ifndef DDSRF_DECOUPLING_FILTER_UNIT_ASSERT_SVH
`define DDSRF_DECOUPLING_FILTER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define DDSRF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ddsrf assertion failed");
`define DDSRF_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("ddsrf assertion failed");
`else
`define DDSRF_ASSERT(label, clk, rst_n, prop)
`define DDSRF_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

[sv/ddsrf_pkg.sv]
`timescale 1ns / 1ps
package ddsrf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int X_W      = 20;
    localparam int OPA_W    = 21;
    localparam int OPB_W    = 17;
    localparam int PROD_W   = OPA_W + OPB_W;
    localparam int ACC_W    = 40;
    localparam int STEP_W   = 5;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 1'b1;

    localparam logic [GAIN_W-1:0] INPUT_GAIN_RST    = 16'd1996;
    localparam logic [GAIN_W-1:0] FEEDBACK_GAIN_RST = 16'd63540;

    localparam logic [STEP_W-1:0] STEP_IDLE = 5'd0;
    localparam logic [STEP_W-1:0] STEP_LAST = 5'd21;

    localparam logic signed [ACC_W-1:0] RND13 = 40'sd4096;
    localparam logic signed [ACC_W-1:0] RND14 = 40'sd8192;
    localparam logic signed [ACC_W-1:0] RND16 = 40'sd32768;
    localparam logic signed [ACC_W-1:0] SAT_HI = 40'sd32767;
    localparam logic signed [ACC_W-1:0] SAT_LO = -40'sd32768;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] d_pos;
        logic signed [SAMPLE_W-1:0] q_pos;
        logic signed [SAMPLE_W-1:0] d_neg;
        logic signed [SAMPLE_W-1:0] q_neg;
        logic signed [SAMPLE_W-1:0] cos_angle;
        logic signed [SAMPLE_W-1:0] sin_angle;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] d_pos_filtered;
        logic signed [SAMPLE_W-1:0] q_pos_filtered;
        logic signed [SAMPLE_W-1:0] d_neg_filtered;
        logic signed [SAMPLE_W-1:0] q_neg_filtered;
    } t_out;

    typedef enum logic [1:0] {A_COS, A_SIN, A_FILT, A_X} t_asel;
    typedef enum logic [2:0] {B_COS, B_SIN, B_C2, B_S2, B_K1, B_K2} t_bsel;
    typedef enum logic [2:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_RAW_SUB} t_accop;
    typedef enum logic [2:0] {WB_NONE, WB_C2, WB_S2, WB_X, WB_FILT} t_wb;
    typedef enum logic [1:0] {JMP_NEXT, JMP_WAIT_IN, JMP_WAIT_OUT} t_jmp;

    typedef struct packed {
        t_asel       a_sel;
        logic [1:0]  a_idx;
        t_bsel       b_sel;
        t_accop      acc_op;
        logic [1:0]  raw_idx;
        t_wb         wb;
        logic [1:0]  wb_idx;
        t_jmp        jmp;
    } t_uop;

    function automatic t_uop mk_uop(input t_asel a_sel, input logic [1:0] a_idx,
                                    input t_bsel b_sel, input t_accop acc_op,
                                    input logic [1:0] raw_idx, input t_wb wb,
                                    input logic [1:0] wb_idx, input t_jmp jmp);
        t_uop u;
        u.a_sel   = a_sel;
        u.a_idx   = a_idx;
        u.b_sel   = b_sel;
        u.acc_op  = acc_op;
        u.raw_idx = raw_idx;
        u.wb      = wb;
        u.wb_idx  = wb_idx;
        u.jmp     = jmp;
        return u;
    endfunction

    // Control store. Filtered index order is dp, qp, dn, qn.
    // A write-back always takes the accumulator before this step's product lands.
    function automatic t_uop ucode(input logic [STEP_W-1:0] step);
        t_uop u;
        case (step)
            5'd0:  u = mk_uop(A_COS,  2'd0, B_COS, ACC_HOLD,    2'd0, WB_NONE, 2'd0, JMP_WAIT_IN);
            5'd1:  u = mk_uop(A_COS,  2'd0, B_COS, ACC_LOAD,    2'd0, WB_NONE, 2'd0, JMP_NEXT);
            5'd2:  u = mk_uop(A_SIN,  2'd0, B_SIN, ACC_SUB,     2'd0, WB_NONE, 2'd0, JMP_NEXT);
            5'd3:  u = mk_uop(A_SIN,  2'd0, B_COS, ACC_LOAD,    2'd0, WB_C2,   2'd0, JMP_NEXT);
            5'd4:  u = mk_uop(A_FILT, 2'd2, B_C2,  ACC_RAW_SUB, 2'd0, WB_S2,   2'd0, JMP_NEXT);
            5'd5:  u = mk_uop(A_FILT, 2'd3, B_S2,  ACC_SUB,     2'd0, WB_NONE, 2'd0, JMP_NEXT);
            5'd6:  u = mk_uop(A_FILT, 2'd3, B_C2,  ACC_RAW_SUB, 2'd1, WB_X,    2'd0, JMP_NEXT);
            5'd7:  u = mk_uop(A_FILT, 2'd2, B_S2,  ACC_ADD,     2'd0, WB_NONE, 2'd0, JMP_NEXT);
            5'd8:  u = mk_uop(A_FILT, 2'd0, B_C2,  ACC_RAW_SUB, 2'd2, WB_X,    2'd1, JMP_NEXT);
            5'd9:  u = mk_uop(A_FILT, 2'd1, B_S2,  ACC_ADD,     2'd0, WB_NONE, 2'd0, JMP_NEXT);
            5'd10: u = mk_uop(A_FILT, 2'd1, B_C2,  ACC_RAW_SUB, 2'd3, WB_X,    2'd2, JMP_NEXT);
            5'd11: u = mk_uop(A_FILT, 2'd0, B_S2,  ACC_SUB,     2'd0, WB_NONE, 2'd0, JMP_NEXT);
            5'd12: u = mk_uop(A_X,    2'd0, B_K1,  ACC_LOAD,    2'd0, WB_X,    2'd3, JMP_NEXT);
            5'd13: u = mk_uop(A_FILT, 2'd0, B_K2,  ACC_ADD,     2'd0, WB_NONE, 2'd0, JMP_NEXT);
            5'd14: u = mk_uop(A_X,    2'd1, B_K1,  ACC_LOAD,    2'd0, WB_FILT, 2'd0, JMP_NEXT);
            5'd15: u = mk_uop(A_FILT, 2'd1, B_K2,  ACC_ADD,     2'd0, WB_NONE, 2'd0, JMP_NEXT);
            5'd16: u = mk_uop(A_X,    2'd2, B_K1,  ACC_LOAD,    2'd0, WB_FILT, 2'd1, JMP_NEXT);
            5'd17: u = mk_uop(A_FILT, 2'd2, B_K2,  ACC_ADD,     2'd0, WB_NONE, 2'd0, JMP_NEXT);
            5'd18: u = mk_uop(A_X,    2'd3, B_K1,  ACC_LOAD,    2'd0, WB_FILT, 2'd2, JMP_NEXT);
            5'd19: u = mk_uop(A_FILT, 2'd3, B_K2,  ACC_ADD,     2'd0, WB_NONE, 2'd0, JMP_NEXT);
            5'd20: u = mk_uop(A_COS,  2'd0, B_COS, ACC_HOLD,    2'd0, WB_FILT, 2'd3, JMP_NEXT);
            5'd21: u = mk_uop(A_COS,  2'd0, B_COS, ACC_HOLD,    2'd0, WB_NONE, 2'd0, JMP_WAIT_OUT);
            default: u = mk_uop(A_COS, 2'd0, B_COS, ACC_HOLD,   2'd0, WB_NONE, 2'd0, JMP_WAIT_OUT);
        endcase
        return u;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > SAT_HI) begin
            r = 16'sh7fff;
        end else if (v < SAT_LO) begin
            r = 16'sh8000;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

[sv/ddsrf_decoupling_filter_unit.sv]
`timescale 1ns / 1ps
// A new request is accepted only in the idle step, once the previous result has moved
// into the output register. The shared multiply-accumulate unit runs one control-store
// step per cycle, pausing only at the idle and last steps, over 19 product steps.
// Reset (synchronous, active low): gains return to 1996 and 63540, the four filter
// states clear to zero, the sequencer returns to its idle step and the output empties.
`include "ddsrf_decoupling_filter_unit_assert.svh"
module ddsrf_decoupling_filter_unit
    import ddsrf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out
);

    logic [GAIN_W-1:0]                r_k1;
    logic [GAIN_W-1:0]                r_k2;
    logic [STEP_W-1:0]                r_step;
    logic [STEP_W-1:0]                n_step;
    t_in                              r_in;
    logic signed [SAMPLE_W-1:0]       r_filt [4];
    logic signed [X_W-1:0]            r_x    [4];
    logic signed [SAMPLE_W-1:0]       r_c2;
    logic signed [SAMPLE_W-1:0]       r_s2;
    logic signed [ACC_W-1:0]          r_acc;
    logic signed [ACC_W-1:0]          n_acc;

    t_uop                             w_uop;
    logic                             w_in_acc;
    logic                             w_out_free;
    logic signed [OPA_W-1:0]          w_op_a;
    logic signed [OPB_W-1:0]          w_op_b;
    logic signed [PROD_W-1:0]         w_prod;
    logic signed [ACC_W-1:0]          w_prod_ext;
    logic signed [SAMPLE_W-1:0]       w_raw;
    logic signed [ACC_W-1:0]          w_raw_ext;
    logic signed [ACC_W-1:0]          w_sum13;
    logic signed [ACC_W-1:0]          w_sum14;
    logic signed [ACC_W-1:0]          w_sum16;
    logic signed [ACC_W-1:0]          w_rnd13;
    logic signed [ACC_W-1:0]          w_rnd14;
    logic signed [ACC_W-1:0]          w_rnd16;

    assign w_uop      = ucode(r_step);
    assign o_in_ready = (r_step == STEP_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !o_out_valid || i_out_ready;

    // Operand selection for the shared multiplier.
    always_comb begin
        case (w_uop.a_sel)
            A_COS:   w_op_a = OPA_W'(r_in.cos_angle);
            A_SIN:   w_op_a = OPA_W'(r_in.sin_angle);
            A_FILT:  w_op_a = OPA_W'(r_filt[w_uop.a_idx]);
            A_X:     w_op_a = OPA_W'(r_x[w_uop.a_idx]);
            default: w_op_a = '0;
        endcase
    end

    always_comb begin
        case (w_uop.b_sel)
            B_COS:   w_op_b = OPB_W'(r_in.cos_angle);
            B_SIN:   w_op_b = OPB_W'(r_in.sin_angle);
            B_C2:    w_op_b = OPB_W'(r_c2);
            B_S2:    w_op_b = OPB_W'(r_s2);
            B_K1:    w_op_b = $signed({1'b0, r_k1});
            B_K2:    w_op_b = $signed({1'b0, r_k2});
            default: w_op_b = '0;
        endcase
    end

    always_comb begin
        case (w_uop.raw_idx)
            2'd0:    w_raw = r_in.d_pos;
            2'd1:    w_raw = r_in.q_pos;
            2'd2:    w_raw = r_in.d_neg;
            default: w_raw = r_in.q_neg;
        endcase
    end

    assign w_prod     = w_op_a * w_op_b;
    assign w_prod_ext = ACC_W'(w_prod);
    assign w_raw_ext  = $signed({{(ACC_W - SAMPLE_W - 14){w_raw[SAMPLE_W-1]}}, w_raw, 14'd0});

    always_comb begin
        case (w_uop.acc_op)
            ACC_LOAD:    n_acc = w_prod_ext;
            ACC_ADD:     n_acc = r_acc + w_prod_ext;
            ACC_SUB:     n_acc = r_acc - w_prod_ext;
            ACC_RAW_SUB: n_acc = w_raw_ext - w_prod_ext;
            default:     n_acc = r_acc;
        endcase
    end

    // Round half up: add half an LSB of the target, then shift arithmetically.
    assign w_sum13 = r_acc + RND13;
    assign w_sum14 = r_acc + RND14;
    assign w_sum16 = r_acc + RND16;
    assign w_rnd13 = w_sum13 >>> 13;
    assign w_rnd14 = w_sum14 >>> 14;
    assign w_rnd16 = w_sum16 >>> 16;

    always_comb begin
        n_step = r_step;
        case (w_uop.jmp)
            JMP_WAIT_IN: begin
                if (w_in_acc) begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            JMP_WAIT_OUT: begin
                if (w_out_free) begin
                    n_step = STEP_IDLE;
                end
            end
            default: n_step = r_step + STEP_W'(1);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k1 <= INPUT_GAIN_RST;
            r_k2 <= FEEDBACK_GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_INPUT_GAIN:    r_k1 <= i_cfg_data[GAIN_W-1:0];
                REG_FEEDBACK_GAIN: r_k2 <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_IDLE;
            o_out_valid <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_filt[i] <= '0;
            end
        end else begin
            r_step <= n_step;
            if (w_uop.jmp == JMP_WAIT_OUT && w_out_free) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            if (w_uop.wb == WB_FILT) begin
                r_filt[w_uop.wb_idx] <= sat16(w_rnd16);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= i_in;
        end
        r_acc <= n_acc;
        case (w_uop.wb)
            WB_C2:   r_c2 <= sat16(w_rnd14);
            WB_S2:   r_s2 <= sat16(w_rnd13);
            WB_X:    r_x[w_uop.wb_idx] <= w_rnd14[X_W-1:0];
            default: ;
        endcase
        if (w_uop.jmp == JMP_WAIT_OUT && w_out_free) begin
            o_out.d_pos_filtered <= r_filt[0];
            o_out.q_pos_filtered <= r_filt[1];
            o_out.d_neg_filtered <= r_filt[2];
            o_out.q_neg_filtered <= r_filt[3];
        end
    end

    `DDSRF_ASSERT(a_accept_starts, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> (r_step == STEP_W'(1)))
    `DDSRF_ASSERT(a_result_from_last, i_clk, i_rst_n, (!o_out_valid ##1 o_out_valid) |-> ($past(r_step) == STEP_LAST))
    `DDSRF_ASSERT(a_hold_when_blocked, i_clk, i_rst_n, (r_step == STEP_LAST && o_out_valid && !i_out_ready) |=> (r_step == STEP_LAST))
    `DDSRF_ASSERT_ALWAYS(a_step_range, i_clk, !i_rst_n || (r_step <= STEP_LAST))

endmodule
